// ----- rtl/chm_pkg.sv -----
package chm_pkg;

  // Table geometry
  localparam int CAPACITY = 8;
  localparam int BKT_W    = $clog2(CAPACITY);
  localparam int LINK_W   = BKT_W + 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Channel field widths
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int IDX_W    = 3;
  localparam int STAT_W   = 2;

  // Link value that ends a chain
  localparam logic [LINK_W-1:0] LINK_END = LINK_W'(CAPACITY);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_CHECK,
    S_MISS,
    S_SCAN,
    S_LINK,
    S_CLAIM,
    S_PAIR_RD,
    S_PAIR_DATA,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [BKT_W-1:0]  slot;
    logic [LINK_W-1:0] link;
    logic [KEY_W-1:0]  hash;
  } bkt_entry_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } pair_entry_t;

  typedef struct packed {
    logic             en;
    logic [BKT_W-1:0] addr;
    bkt_entry_t       data;
  } bkt_wr_t;

  typedef struct packed {
    logic             en;
    logic [BKT_W-1:0] addr;
    pair_entry_t      data;
  } pair_wr_t;

endpackage

// ----- rtl/chm_if.sv -----
interface chm_in_if import chm_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;
  logic [IDX_W-1:0] pair_index;

  modport source (output valid, output command, output key, output value,
                  output pair_index, input ready);
  modport sink   (input valid, input command, input key, input value,
                  input pair_index, output ready);
endinterface

interface chm_out_if import chm_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [KEY_W-1:0]  result_key;
  logic [VAL_W-1:0]  result_value;
  logic [CNT_W-1:0]  entry_count;

  modport source (output valid, output status, output result_key,
                  output result_value, output entry_count, input ready);
  modport sink   (input valid, input status, input result_key,
                  input result_value, input entry_count, output ready);
endinterface

// ----- rtl/chm_ram.sv -----
module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read: old data on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/chm_engine.sv -----
module chm_engine import chm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  chm_in_if.sink            in_ch,
  chm_out_if.source         out_ch,
  output bkt_wr_t           bkt_wr,
  output logic [BKT_W-1:0]  bkt_raddr,
  input  bkt_entry_t        bkt_rdata,
  output pair_wr_t          pair_wr,
  output logic [BKT_W-1:0]  pair_raddr,
  input  pair_entry_t       pair_rdata
);

  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [VAL_W-1:0]  value_r;
  logic [BKT_W-1:0]  cur_r;
  logic [BKT_W-1:0]  tail_r;
  bkt_entry_t        tail_ent_r;
  logic [BKT_W-1:0]  cand_r;
  logic [CNT_W-1:0]  step_r;
  logic [BKT_W-1:0]  pair_addr_r;
  logic [CAPACITY-1:0] used_r;
  logic [CNT_W-1:0]  count_r;
  status_t           res_status_r;
  logic [KEY_W-1:0]  res_key_r;
  logic [VAL_W-1:0]  res_val_r;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [KEY_W-1:0]  out_key_r;
  logic [VAL_W-1:0]  out_val_r;
  logic [CNT_W-1:0]  out_count_r;

  logic              accept;
  logic              load_out;
  logic              hit;
  logic              chain_end;
  logic              step_limit;
  logic              table_full;
  logic [BKT_W-1:0]  home;
  logic [BKT_W-1:0]  in_home;
  logic              idx_ok;

  // Capacity is a power of two: key mod capacity is the low bits
  assign home       = key_r[BKT_W-1:0];
  assign in_home    = in_ch.key[BKT_W-1:0];
  assign hit        = (bkt_rdata.hash == key_r);
  assign chain_end  = (bkt_rdata.link >= LINK_END);
  assign step_limit = (step_r == CNT_W'(CAPACITY - 1));
  assign table_full = (count_r >= CNT_W'(CAPACITY));
  assign idx_ok     = (CNT_W'(in_ch.pair_index) < count_r);
  assign accept     = in_ch.valid && in_ch.ready;

  assign bkt_raddr  = cur_r;
  assign pair_raddr = pair_addr_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (cmd_t'(in_ch.command) == CMD_CLEAR) begin
            state_nxt = S_RESULT;
          end else if (cmd_t'(in_ch.command) == CMD_READ) begin
            state_nxt = idx_ok ? S_PAIR_RD : S_RESULT;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK:  state_nxt = used_r[cur_r] ? S_CHECK : S_MISS;
      S_CHECK: begin
        if (hit) begin
          state_nxt = (cmd_r == CMD_FIND) ? S_PAIR_RD : S_RESULT;
        end else if (chain_end || step_limit) begin
          state_nxt = S_MISS;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_MISS: begin
        priority if (cmd_r == CMD_FIND || table_full) begin
          state_nxt = S_RESULT;
        end else if (!used_r[home]) begin
          state_nxt = S_CLAIM;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (!used_r[cand_r]) begin
          state_nxt = S_LINK;
        end else if (step_limit) begin
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_LINK:      state_nxt = S_CLAIM;
      S_CLAIM:     state_nxt = S_RESULT;
      S_PAIR_RD:   state_nxt = S_PAIR_DATA;
      S_PAIR_DATA: state_nxt = S_RESULT;
      S_RESULT:    state_nxt = load_out ? S_IDLE : S_RESULT;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Outputs: handshake and memory writes
  always_comb begin
    in_ch.ready = (state_r == S_IDLE);
    load_out    = (state_r == S_RESULT) && (!out_valid_r || out_ch.ready);
    bkt_wr      = '0;
    pair_wr     = '0;
    unique case (state_r)
      S_CHECK: begin
        // Update in place: the stored key equals the probe key on a hit
        if (hit && cmd_r == CMD_INSERT) begin
          pair_wr.en         = 1'b1;
          pair_wr.addr       = bkt_rdata.slot;
          pair_wr.data.key   = key_r;
          pair_wr.data.value = value_r;
        end
      end
      S_LINK: begin
        bkt_wr.en        = 1'b1;
        bkt_wr.addr      = tail_r;
        bkt_wr.data.slot = tail_ent_r.slot;
        bkt_wr.data.link = LINK_W'(cand_r);
        bkt_wr.data.hash = tail_ent_r.hash;
      end
      S_CLAIM: begin
        bkt_wr.en          = 1'b1;
        bkt_wr.addr        = cand_r;
        bkt_wr.data.slot   = count_r[BKT_W-1:0];
        bkt_wr.data.link   = LINK_END;
        bkt_wr.data.hash   = key_r;
        pair_wr.en         = 1'b1;
        pair_wr.addr       = count_r[BKT_W-1:0];
        pair_wr.data.key   = key_r;
        pair_wr.data.value = value_r;
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && cmd_t'(in_ch.command) == CMD_CLEAR) begin
        used_r  <= '0;
        count_r <= '0;
      end else if (state_r == S_CLAIM) begin
        used_r[cand_r] <= 1'b1;
        count_r        <= count_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_r        <= cmd_t'(in_ch.command);
          key_r        <= in_ch.key;
          value_r      <= in_ch.value;
          pair_addr_r  <= in_ch.pair_index;
          cur_r        <= in_home;
          tail_r       <= in_home;
          step_r       <= '0;
          res_key_r    <= in_ch.key;
          res_val_r    <= '0;
          res_status_r <= (cmd_t'(in_ch.command) == CMD_READ && !idx_ok) ? ST_RANGE : ST_OK;
        end
      end
      S_CHECK: begin
        tail_r     <= cur_r;
        tail_ent_r <= bkt_rdata;
        if (hit) begin
          pair_addr_r <= bkt_rdata.slot;
          if (cmd_r == CMD_INSERT) begin
            res_val_r <= value_r;
          end
        end else if (!chain_end && !step_limit) begin
          cur_r  <= bkt_rdata.link[BKT_W-1:0];
          step_r <= step_r + 1'b1;
        end
      end
      S_MISS: begin
        priority if (cmd_r == CMD_FIND) begin
          res_status_r <= ST_MISSING;
        end else if (table_full) begin
          res_status_r <= ST_FULL;
        end else if (!used_r[home]) begin
          cand_r <= home;
        end else begin
          cand_r <= tail_r + 1'b1;
          step_r <= CNT_W'(1);
        end
      end
      S_SCAN: begin
        if (used_r[cand_r]) begin
          if (step_limit) begin
            res_status_r <= ST_FULL;
          end else begin
            cand_r <= cand_r + 1'b1;
            step_r <= step_r + 1'b1;
          end
        end
      end
      S_CLAIM: begin
        res_val_r <= value_r;
      end
      S_PAIR_DATA: begin
        res_val_r <= pair_rdata.value;
        if (cmd_r == CMD_READ) begin
          res_key_r <= pair_rdata.key;
        end
      end
      S_RESULT: begin
        if (load_out) begin
          out_status_r <= res_status_r;
          out_key_r    <= res_key_r;
          out_val_r    <= res_val_r;
          out_count_r  <= count_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.result_key   = out_key_r;
  assign out_ch.result_value = out_val_r;
  assign out_ch.entry_count  = out_count_r;

endmodule

// ----- rtl/coalesced_hash_map.sv -----
// One item at a time: the chain walk reads each bucket through the bucket memory read
// port in a walk state and compares it in a check state; the free-bucket scan tests
// the used marks one bucket per scan step.
// Reset: synchronous, active low; clears used marks, pair count, sequencer and result
// valid. Bucket and pair memories are not cleared.
module coalesced_hash_map import chm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  chm_in_if.sink    in_ch,
  chm_out_if.source out_ch
);

  bkt_wr_t          bkt_wr;
  logic [BKT_W-1:0] bkt_raddr;
  bkt_entry_t       bkt_rdata;
  pair_wr_t         pair_wr;
  logic [BKT_W-1:0] pair_raddr;
  pair_entry_t      pair_rdata;

  // Sequencer: walks chains, scans for a free bucket, links and claims,
  // and holds the result register so a new item may transfer while the
  // previous result waits.
  chm_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .bkt_wr     (bkt_wr),
    .bkt_raddr  (bkt_raddr),
    .bkt_rdata  (bkt_rdata),
    .pair_wr    (pair_wr),
    .pair_raddr (pair_raddr),
    .pair_rdata (pair_rdata)
  );

  // Bucket memory: pair slot, link and stored hash per bucket.
  // Used marks live in flip-flops inside the sequencer.
  chm_ram #(
    .WIDTH ($bits(bkt_entry_t)),
    .DEPTH (CAPACITY)
  ) u_bkt_ram (
    .clk   (clk),
    .we    (bkt_wr.en),
    .waddr (bkt_wr.addr),
    .wdata (bkt_wr.data),
    .raddr (bkt_raddr),
    .rdata (bkt_rdata)
  );

  // Pair memory in insertion order: key and value per slot.
  chm_ram #(
    .WIDTH ($bits(pair_entry_t)),
    .DEPTH (CAPACITY)
  ) u_pair_ram (
    .clk   (clk),
    .we    (pair_wr.en),
    .waddr (pair_wr.addr),
    .wdata (pair_wr.data),
    .raddr (pair_raddr),
    .rdata (pair_rdata)
  );

`ifndef SYNTHESIS
  // One item in flight: ready drops after every input transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while an item is in flight");

  // Stored count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.entry_count <= CNT_W'(CAPACITY)))
    else $error("entry count beyond capacity");

  // Any failure status carries a zero value
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_OK) |-> (out_ch.result_value == '0))
    else $error("non-zero value with failure status");
`endif

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import chm_pkg::*;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int RANDOM_ITEMS = 1525;
  localparam int CALM_ITEMS   = 150;   // last stretch with no idling on either side
  localparam int POOL_SIZE    = 12;    // more keys than buckets, so the table fills up
  localparam int HOLD_CYCLES  = 200;   // long result back-pressure
  localparam int DRAIN_CYCLES = 40;    // comfortably above the worst insert latency

  // One expected result, as the block should present it
  typedef struct {
    status_t          status;
    logic [KEY_W-1:0] rkey;
    logic [VAL_W-1:0] rval;
    logic [CNT_W-1:0] count;
  } map_reply_t;

  // Shadow copy of the coalesced table: predicts each reply from the accepted
  // requests and checks the block's replies against them in order.
  class hash_map_mirror;
    bit               used    [CAPACITY];
    bit [BKT_W-1:0]   slot_of [CAPACITY];
    bit [LINK_W-1:0]  link_of [CAPACITY];
    bit [KEY_W-1:0]   hash_of [CAPACITY];
    bit [KEY_W-1:0]   pair_key[CAPACITY];
    bit [VAL_W-1:0]   pair_val[CAPACITY];
    int unsigned      stored;
    map_reply_t       awaited_replies[$];
    int               errors;

    // Bucket holding key, or CAPACITY when absent; tail is the last bucket visited
    function int chase(bit [KEY_W-1:0] key, output int tail);
      int b;
      b    = int'(key % CAPACITY);
      tail = b;
      for (int steps = 0; steps < CAPACITY; steps++) begin
        if (!used[b]) return CAPACITY;
        tail = b;
        if (hash_of[b] == key) return b;
        if (link_of[b] >= CAPACITY) return CAPACITY;
        b = int'(link_of[b]);
      end
      return CAPACITY;
    endfunction

    function void claim(int b, bit [KEY_W-1:0] key, bit [VAL_W-1:0] value);
      used[b]          = 1'b1;
      slot_of[b]       = BKT_W'(stored);
      link_of[b]       = LINK_END;
      hash_of[b]       = key;
      pair_key[stored] = key;
      pair_val[stored] = value;
      stored++;
    endfunction

    function status_t put(bit [KEY_W-1:0] key, bit [VAL_W-1:0] value);
      int home;
      int hit;
      int tail;
      int cand;
      home = int'(key % CAPACITY);
      hit  = chase(key, tail);
      // a present key is updated even when the table is full
      if (hit < CAPACITY) begin
        pair_val[slot_of[hit]] = value;
        return ST_OK;
      end
      if (stored >= CAPACITY) return ST_FULL;
      if (!used[home]) begin
        claim(home, key, value);
        return ST_OK;
      end
      // chain ended: scan circularly for the next free bucket and link it
      cand = tail;
      for (int n = 1; n < CAPACITY; n++) begin
        cand = (tail + n) % CAPACITY;
        if (!used[cand]) break;
      end
      if (used[cand]) return ST_FULL;
      link_of[tail] = LINK_W'(cand);
      claim(cand, key, value);
      return ST_OK;
    endfunction

    function void note_request(cmd_t cmd, bit [KEY_W-1:0] key, bit [VAL_W-1:0] value,
                               bit [IDX_W-1:0] idx);
      map_reply_t r;
      int         hit;
      int         tail;
      r.status = ST_OK;
      r.rkey   = key;
      r.rval   = '0;
      case (cmd)
        CMD_INSERT: begin
          r.status = put(key, value);
          if (r.status == ST_OK) r.rval = value;
        end
        CMD_FIND: begin
          hit = chase(key, tail);
          if (hit < CAPACITY) r.rval = pair_val[slot_of[hit]];
          else r.status = ST_MISSING;
        end
        CMD_READ: begin
          if (idx < stored) begin
            r.rkey = pair_key[idx];
            r.rval = pair_val[idx];
          end else begin
            r.status = ST_RANGE;
          end
        end
        default: begin
          foreach (used[i]) used[i] = 1'b0;
          stored = 0;
        end
      endcase
      r.count = CNT_W'(stored);
      awaited_replies.push_back(r);
    endfunction

    function void check_reply(logic [STAT_W-1:0] status, logic [KEY_W-1:0] rkey,
                              logic [VAL_W-1:0] rval, logic [CNT_W-1:0] count);
      map_reply_t e;
      if (awaited_replies.size() == 0) begin
        $error("result transfer with no request outstanding");
        errors++;
        return;
      end
      e = awaited_replies.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        errors++;
      end
      if (rkey !== e.rkey) begin
        $error("result_key: expected %h, got %h", e.rkey, rkey);
        errors++;
      end
      if (rval !== e.rval) begin
        $error("result_value: expected %h, got %h", e.rval, rval);
        errors++;
      end
      if (count !== e.count) begin
        $error("entry_count: expected %0d, got %0d", e.count, count);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic calm;       // no idling on either side from here on
  logic hold_off;   // long stall of the result channel

  chm_in_if  in_bus ();
  chm_out_if out_bus ();

  coalesced_hash_map dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus.sink),
    .out_ch (out_bus.source)
  );

  hash_map_mirror mirror = new();
  int             accepted;
  int unsigned    cycles;
  bit [KEY_W-1:0] pool[POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** coalesced_hash_map: FAILED **");
      $finish;
    end
  end

  // Offer one request, hold it until the transfer, then note it
  task automatic send(cmd_t cmd, bit [KEY_W-1:0] key, bit [VAL_W-1:0] value,
                      bit [IDX_W-1:0] idx);
    int gap;
    gap = 0;
    if (calm !== 1'b1 && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.command    <= cmd;
    in_bus.key        <= key;
    in_bus.value      <= value;
    in_bus.pair_index <= idx;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    mirror.note_request(cmd, key, value, idx);
    accepted++;
  endtask

  // New key set for a session; skew low bits on some so chains collide hard
  task automatic refresh_pool();
    bit skew;
    skew = $urandom_range(0, 1);
    foreach (pool[i]) begin
      pool[i] = $urandom;
      if (skew) pool[i][2:0] = 3'($urandom_range(0, 2));
    end
  endtask

  task automatic send_random_item();
    cmd_t           cmd;
    bit [KEY_W-1:0] key;
    int             roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      // noise: anything the fields allow
      send(cmd_t'($urandom_range(0, 3)), $urandom, $urandom, 3'($urandom_range(0, 7)));
    end else begin
      roll = $urandom_range(0, 29);
      key  = pool[$urandom_range(0, POOL_SIZE - 1)];
      if (roll == 0) begin
        cmd = CMD_CLEAR;
        refresh_pool();
      end else if (roll < 16) begin
        cmd = CMD_INSERT;
      end else if (roll < 24) begin
        cmd = CMD_FIND;
      end else begin
        cmd = CMD_READ;
      end
      send(cmd, key, $urandom, 3'($urandom_range(0, 7)));
    end
  endtask

  // Result side: random stall bursts, with quiet stretches between them
  initial begin
    int  stall;
    bit  lively;
    stall  = 0;
    lively = 1'b1;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) == 0) lively = !lively;
      if (hold_off === 1'b1) begin
        out_bus.ready <= 1'b0;
      end else if (calm === 1'b1) begin
        out_bus.ready <= 1'b1;
      end else if (stall > 0) begin
        out_bus.ready <= 1'b0;
        stall--;
      end else if (lively && $urandom_range(0, 7) == 0) begin
        out_bus.ready <= 1'b0;
        stall = $urandom_range(1, 6) - 1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Long hold-off while requests keep coming, so the block backs up its input
  initial begin
    hold_off <= 1'b0;
    @(posedge clk);
    while (accepted < 400) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
      mirror.check_reply(out_bus.status, out_bus.result_key, out_bus.result_value,
                         out_bus.entry_count);
  end

  initial begin
    rst_n             <= 1'b0;
    calm              <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.command    <= CMD_INSERT;
    in_bus.key        <= '0;
    in_bus.value      <= '0;
    in_bus.pair_index <= '0;
    accepted = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table first
    send(CMD_READ,   32'h0000_0000, 32'h0000_0000, 3'd0);  // index beyond count
    send(CMD_FIND,   32'h0000_0000, 32'hFFFF_FFFF, 3'd7);  // key not found
    // Extremes of key and value
    send(CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 3'd0);
    send(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
    // Same home bucket: chain grows by claiming the next free buckets
    send(CMD_INSERT, 32'h0000_0008, 32'h1234_5678, 3'd1);
    send(CMD_INSERT, 32'h0000_0010, 32'h8765_4321, 3'd2);
    // Home bucket already taken by another chain: chains coalesce
    send(CMD_INSERT, 32'h0000_0001, 32'hA5A5_A5A5, 3'd3);
    send(CMD_FIND,   32'h0000_0010, 32'h0000_0000, 3'd4);
    send(CMD_FIND,   32'h0000_0018, 32'h0000_0000, 3'd5);  // walks whole chain, misses
    send(CMD_INSERT, 32'h0000_0008, 32'h5A5A_5A5A, 3'd6);  // update in place
    // Fill the table
    send(CMD_INSERT, 32'hA5A5_5A5A, 32'h0F0F_0F0F, 3'd0);
    send(CMD_INSERT, 32'h8000_0003, 32'hF0F0_F0F0, 3'd0);
    send(CMD_INSERT, 32'h7FFF_FFFC, 32'h3333_CCCC, 3'd0);
    // New key when full, then update of a present key when full
    send(CMD_INSERT, 32'hDEAD_BEEF, 32'hCAFE_F00D, 3'd0);
    send(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0001, 3'd0);
    send(CMD_FIND,   32'hFFFF_FFFF, 32'h0000_0000, 3'd0);
    send(CMD_READ,   32'h1111_1111, 32'h0000_0000, 3'd0);
    send(CMD_READ,   32'h2222_2222, 32'h0000_0000, 3'd3);
    send(CMD_READ,   32'h3333_3333, 32'h0000_0000, 3'd7);
    // Clear, then confirm the table is empty
    send(CMD_CLEAR,  32'h5555_AAAA, 32'hFFFF_FFFF, 3'd7);
    send(CMD_READ,   32'h0000_0000, 32'h0000_0000, 3'd0);
    send(CMD_FIND,   32'h0000_0000, 32'h0000_0000, 3'd0);
    // Wrap-around scan from the last bucket
    send(CMD_INSERT, 32'h0000_0007, 32'h0000_0077, 3'd0);
    send(CMD_INSERT, 32'h0000_000F, 32'h0000_00FF, 3'd0);
    send(CMD_CLEAR,  32'hFFFF_FFFF, 32'h0000_0000, 3'd0);

    refresh_pool();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm <= 1'b1;
      send_random_item();
    end
    in_bus.valid <= 1'b0;

    // Drain outstanding replies, then allow for any late stray transfer
    while (mirror.awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("** coalesced_hash_map: PASSED **");
    end else begin
      $display("** coalesced_hash_map: FAILED **");
    end
    $finish;
  end

endmodule
